FILE: hw/rtl/ille_pkg.sv
// Shared types and command and status codes of the indexed linked list engine.
package ille_pkg;
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_SEARCH = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [8:0] position;
		logic [31:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] read_word;
		logic found;
		logic [8:0] entry_count;
	} rsp_word_t;
endpackage

FILE: hw/rtl/ille_cmd_if.sv
// Valid/ready channel interfaces for command and response words.
interface ille_cmd_if;
	import ille_pkg::*;
	logic valid;
	logic ready;
	cmd_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ille_rsp_if;
	import ille_pkg::*;
	logic valid;
	logic ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ille_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ille_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/indexed_linked_list_engine.sv
// Indexed linked list engine: ordered list of words kept in linked node memories.
// After reset the engine loads the free-slot stack with every slot index, one
// entry per cycle, and takes no command until that is done.
// One command is taken at a time. A command rejected with a range or full
// status goes straight to the response. Otherwise it walks the nodes (read:
// position+1, remove: position or one at the front, insert: position-1 in the
// middle and none at either end, search: up to the entry count), so up to
// CAPACITY nodes. The walk is paced by the registered read of the link memory.
// Then a remove updates the list in S_RMRD and an insert in S_POP followed,
// when not at the front, by S_LINK. S_RSP loads the response, held in an output
// register until taken. The next command is accepted from the cycle after that.
module indexed_linked_list_engine #(
	parameter int CAPACITY = 256,
	parameter int DATA_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	ille_cmd_if.sink cmd,
	ille_rsp_if.source rsp
);
	import ille_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_SRCH  = 3'd2;
	localparam logic [2:0] S_RMRD  = 3'd3;
	localparam logic [2:0] S_POP   = 3'd4;
	localparam logic [2:0] S_RSP   = 3'd5;
	localparam logic [2:0] S_LINK  = 3'd6;
	localparam logic [2:0] S_INIT  = 3'd7;

	logic [2:0] state_q;
	logic [1:0] cmd_q;
	logic [CW-1:0] pos_q, cnt_q, idx_q, ftop_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [AW-1:0] head_q, tail_q, cur_q, prev_q, init_q;
	logic [1:0] st_q;
	logic [31:0] rdw_q;
	logic fnd_q;
	logic [8:0] ecnt_q;
	logic rsp_v_q;

	logic dwe, lwe, fwe;
	logic [AW-1:0] dwa, lwa, lra, dra, fwa, fra, lwd, fwd;
	logic [DATA_WIDTH-1:0] dwd, drd;
	logic [AW-1:0] lrd, frd;

	ille_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data (
		.clk(clk), .we(dwe), .waddr(dwa), .wdata(dwd), .raddr(dra), .rdata(drd));
	ille_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link (
		.clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd));
	ille_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
		.clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd));

	logic [AW-1:0] fslot;
	logic [DATA_WIDTH-1:0] inval;
	logic [CW-1:0] inpos;
	logic [1:0] acc_st;

	assign inval = DATA_WIDTH'(cmd.data.value);
	assign inpos = CW'(cmd.data.position);
	assign fslot = frd;
	assign cmd.ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.data = {st_q, rdw_q, fnd_q, ecnt_q};

	always_comb begin
		acc_st = ST_OK;
		case (cmd.data.command)
			CMD_INSERT: begin
				if (inpos > cnt_q) begin
					acc_st = ST_RANGE;
				end else if (cnt_q >= CAP || ftop_q == '0) begin
					acc_st = ST_FULL;
				end
			end
			CMD_SEARCH: begin
				acc_st = ST_OK;
			end
			default: begin
				if (inpos >= cnt_q) begin
					acc_st = ST_RANGE;
				end
			end
		endcase
	end

	always_comb begin
		dwe = 1'b0; lwe = 1'b0; fwe = 1'b0;
		dwa = '0; dwd = val_q; lwa = '0; lwd = '0; fwa = '0; fwd = '0;
		dra = cur_q; lra = cur_q;
		fra = AW'(ftop_q - CW'(1));
		if (state_q == S_IDLE) begin
			dra = head_q; lra = head_q;
		end else if (state_q == S_SRCH ||
				(state_q == S_WALK && !(cmd_q == CMD_REMOVE && pos_q == '0))) begin
			dra = lrd; lra = lrd;
		end
		if (state_q == S_INIT) begin
			fwe = 1'b1;
			fwa = init_q;
			fwd = init_q;
		end
		if (state_q == S_POP) begin
			dwe = 1'b1; dwa = fslot;
			lwe = 1'b1; lwa = fslot;
			if (pos_q == '0) begin
				lwd = (cnt_q == '0) ? '0 : head_q;
			end else if (pos_q == cnt_q) begin
				lwd = '0;
			end else begin
				lwd = lrd;
			end
		end
		if (state_q == S_RMRD) begin
			fwe = 1'b1;
			fwa = AW'(ftop_q);
			fwd = cur_q;
			lwa = prev_q;
			lwd = (pos_q == cnt_q - CW'(1)) ? '0 : lrd;
			lwe = (pos_q != '0);
		end
		if (state_q == S_LINK) begin
			lwe = 1'b1;
			lwa = prev_q;
			lwd = cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			rsp_v_q <= 1'b0;
			ftop_q <= CAP;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			cmd_q <= CMD_INSERT;
			pos_q <= '0;
			idx_q <= '0;
			val_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			st_q <= ST_OK;
			rdw_q <= '0;
			fnd_q <= 1'b0;
			ecnt_q <= '0;
		end else begin
			if (rsp_v_q && rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						cmd_q <= cmd.data.command;
						pos_q <= inpos;
						val_q <= inval;
						idx_q <= (cmd.data.command == CMD_INSERT) ? CW'(1) : '0;
						cur_q <= head_q;
						prev_q <= head_q;
						st_q <= acc_st;
						rdw_q <= '0;
						fnd_q <= 1'b0;
						ecnt_q <= 9'(cnt_q);
						if (acc_st != ST_OK) begin
							state_q <= S_RSP;
						end else begin
							case (cmd.data.command)
								CMD_INSERT: begin
									state_q <= (inpos == '0 || inpos == cnt_q ||
										inpos == CW'(1)) ? S_POP : S_WALK;
								end
								CMD_SEARCH: begin
									state_q <= (cnt_q == '0) ? S_RSP : S_SRCH;
								end
								default: begin
									state_q <= S_WALK;
								end
							endcase
						end
					end
				end
				S_WALK: begin
					if (cmd_q == CMD_INSERT) begin
						if (idx_q + CW'(1) == pos_q) begin
							state_q <= S_POP;
						end
						cur_q <= lrd; prev_q <= lrd; idx_q <= idx_q + CW'(1);
					end else if (cmd_q == CMD_READ) begin
						if (idx_q == pos_q) begin
							rdw_q <= 32'(drd);
							state_q <= S_RSP;
						end
						cur_q <= lrd; idx_q <= idx_q + CW'(1);
					end else begin
						if (pos_q == '0) begin
							state_q <= S_RMRD;
						end else if (idx_q + CW'(1) == pos_q) begin
							cur_q <= lrd;
							state_q <= S_RMRD;
						end else begin
							cur_q <= lrd; prev_q <= lrd;
						end
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SRCH: begin
					if (drd == val_q) begin
						fnd_q <= 1'b1; state_q <= S_RSP;
					end else if (idx_q + CW'(1) == cnt_q) begin
						state_q <= S_RSP;
					end
					cur_q <= lrd; idx_q <= idx_q + CW'(1);
				end
				S_RMRD: begin
					if (pos_q == '0) begin
						head_q <= (cnt_q == CW'(1)) ? '0 : lrd;
						if (cnt_q == CW'(1)) tail_q <= '0;
					end else if (pos_q == cnt_q - CW'(1)) begin
						tail_q <= prev_q;
					end
					if (ftop_q < CAP) begin
						ftop_q <= ftop_q + CW'(1);
					end
					cnt_q <= cnt_q - CW'(1);
					ecnt_q <= 9'(cnt_q - CW'(1));
					state_q <= S_RSP;
				end
				S_POP: begin
					ftop_q <= ftop_q - CW'(1);
					if (pos_q == '0) begin
						head_q <= fslot;
						if (cnt_q == '0) tail_q <= fslot;
					end else if (pos_q == cnt_q) begin
						tail_q <= fslot;
						prev_q <= tail_q;
					end
					cnt_q <= cnt_q + CW'(1);
					ecnt_q <= 9'(cnt_q + CW'(1));
					cur_q <= fslot;
					state_q <= (pos_q == '0) ? S_RSP : S_LINK;
				end
				S_LINK: begin
					state_q <= S_RSP;
				end
				S_RSP: begin
					rsp_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: test/tb_indexed_linked_list_engine.sv
// Testbench of the indexed linked list engine: random commands checked against a list model.
module tb_indexed_linked_list_engine;
	import ille_pkg::*;

	localparam int CAP = 256;
	localparam int LIMIT = 3000000;

	class list_scoreboard;
		logic [31:0] entries[$];
		rsp_word_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_command(cmd_word_t c);
			rsp_word_t r;
			int p;
			p = int'(c.position);
			r = '0;
			r.status = ST_OK;
			case (c.command)
				CMD_INSERT: begin
					if (p > entries.size()) r.status = ST_RANGE;
					else if (entries.size() >= CAP) r.status = ST_FULL;
					else entries.insert(p, c.value);
				end
				CMD_REMOVE: begin
					if (p >= entries.size()) r.status = ST_RANGE;
					else entries.delete(p);
				end
				CMD_READ: begin
					if (p >= entries.size()) r.status = ST_RANGE;
					else r.read_word = entries[p];
				end
				default: begin
					foreach (entries[i]) if (entries[i] == c.value) r.found = 1'b1;
				end
			endcase
			r.entry_count = 9'(entries.size());
			pending.push_back(r);
		endfunction

		function void check_response(rsp_word_t a);
			rsp_word_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected word %h", $time, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status || a.read_word !== e.read_word ||
					a.found !== e.found || a.entry_count !== e.entry_count) begin
				$display("%0t mismatch expected st=%0d rd=%h f=%0d n=%0d",
					$time, e.status, e.read_word, e.found, e.entry_count,
					" actual st=%0d rd=%h f=%0d n=%0d",
					a.status, a.read_word, a.found, a.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	ille_cmd_if cmd();
	ille_rsp_if rsp();
	list_scoreboard sb = new();
	int cycles = 0;
	bit calm = 1'b0;

	indexed_linked_list_engine uut (.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .rsp(rsp.source));

	always #5 clk = ~clk;

	initial begin
		cmd.valid = 1'b0;
		cmd.data = '0;
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) rsp.ready <= calm || ($urandom_range(99) >= 29);
		if (rsp.valid && rsp.ready) sb.check_response(rsp.data);
		if (cmd.valid && cmd.ready) sb.note_command(cmd.data);
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send(logic [1:0] op, int pos, logic [31:0] val);
		cmd_word_t w;
		w.command = op;
		w.position = 9'(pos);
		w.value = val;
		while (!calm && $urandom_range(99) < 29) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data <= w;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	function automatic int pick_pos(int n);
		case ($urandom_range(9))
			0: return n;
			1: return $urandom_range(511);
			2: return 0;
			default: return n == 0 ? 0 : $urandom_range(n - 1);
		endcase
	endfunction

	initial begin
		int n;
		logic [1:0] op;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(CMD_REMOVE, 0, 0);
		send(CMD_READ, 0, 0);
		send(CMD_SEARCH, 0, 0);
		send(CMD_INSERT, 1, 32'h1);
		send(CMD_INSERT, 0, 32'hFFFF_FFFF);
		send(CMD_INSERT, 1, 32'h0);
		send(CMD_INSERT, 1, 32'hA5A5_5A5A);
		send(CMD_READ, 1, 0);
		send(CMD_READ, 2, 0);
		send(CMD_READ, 3, 0);
		send(CMD_SEARCH, 0, 32'hFFFF_FFFF);
		send(CMD_SEARCH, 0, 32'h1234_5678);
		send(CMD_REMOVE, 2, 0);
		send(CMD_REMOVE, 1, 0);
		send(CMD_REMOVE, 511, 0);
		send(CMD_REMOVE, 0, 0);
		send(CMD_READ, 0, 0);
		// fill to capacity and overflow
		for (int i = 0; i < CAP; i++) send(CMD_INSERT, i == 0 ? 0 : $urandom_range(i), $urandom);
		send(CMD_INSERT, CAP, 32'h5);
		send(CMD_INSERT, 0, 32'h5);
		send(CMD_INSERT, 257, 32'h5);
		send(CMD_READ, 255, 0);
		send(CMD_REMOVE, 255, 0);
		for (int i = 0; i < 570; i++) begin
			calm = (i >= 200 && i < 300);
			n = sb.entries.size();
			case ($urandom_range(9))
				0, 1, 2, 3: op = CMD_INSERT;
				4, 5, 6: op = CMD_REMOVE;
				7, 8: op = CMD_READ;
				default: op = CMD_SEARCH;
			endcase
			if (op == CMD_SEARCH && n > 0 && $urandom_range(1))
				send(op, $urandom_range(511), sb.entries[$urandom_range(n - 1)]);
			else
				send(op, pick_pos(n), $urandom);
		end
		cmd.valid <= 1'b0;
		calm = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
